// File: rtl/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit checker
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// same-cycle implication, reset-qualified
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation codes and the pipeline payload type.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAG_W      = 64;
    localparam int DEN_W      = 64;
    localparam int QBITS      = 33;                    // quotient bits below 2^33
    localparam int QUO_W      = QBITS + 1;             // room for the round-up
    localparam int DIV_STAGES = QBITS + 2;             // init, one per bit, round
    localparam int DIV_W      = MAG_W + FRAC_BITS;     // scaled dividend
    localparam int PREM_W     = DIV_W - QBITS;         // initial partial remainder

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [MAG_W-1:0] RND_HALF = MAG_W'((64'd1 << FRAC_BITS) >> 1);

    typedef struct packed {
        logic [1:0]       op;
        logic             neg_r;
        logic             neg_i;
        logic [MAG_W-1:0] mag_r;
        logic [MAG_W-1:0] mag_i;
        logic [DEN_W-1:0] den;
        logic             dz;
    } t_prep;

endpackage

// File: rtl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Products, sums and sign/magnitude conversion in three register stages.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic signed [31:0]   i_a_real,
    input  logic signed [31:0]   i_a_imag,
    input  logic signed [31:0]   i_b_real,
    input  logic signed [31:0]   i_b_imag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cau_pkg::t_prep       o_data
);
    import cau_pkg::*;

    logic               r1_v, r2_v, r3_v;
    logic               en;
    logic [1:0]         r1_op, r2_op;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic [63:0]        r1_sq_r, r1_sq_i;
    logic signed [32:0] r1_s_r, r1_s_i;
    logic signed [64:0] n2_x_r, n2_x_i, r2_x_r, r2_x_i;
    logic [DEN_W-1:0]   r2_den;
    t_prep              n3_data, r3_data;

    // whole pipe moves unless the last stage holds a transaction that is not taken
    assign en      = !r3_v || i_ready;
    assign o_ready = en;
    assign o_valid = r3_v;
    assign o_data  = r3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_op;
            r1_p_rr <= 64'(i_a_real) * 64'(i_b_real);
            r1_p_ii <= 64'(i_a_imag) * 64'(i_b_imag);
            r1_p_ri <= 64'(i_a_real) * 64'(i_b_imag);
            r1_p_ir <= 64'(i_a_imag) * 64'(i_b_real);
            r1_sq_r <= 64'(64'(i_b_real) * 64'(i_b_real));
            r1_sq_i <= 64'(64'(i_b_imag) * 64'(i_b_imag));
            r1_s_r  <= (i_op == OP_SUB) ? 33'(i_a_real) - 33'(i_b_real)
                                        : 33'(i_a_real) + 33'(i_b_real);
            r1_s_i  <= (i_op == OP_SUB) ? 33'(i_a_imag) - 33'(i_b_imag)
                                        : 33'(i_a_imag) + 33'(i_b_imag);
            r2_op   <= r1_op;
            r2_x_r  <= n2_x_r;
            r2_x_i  <= n2_x_i;
            r2_den  <= r1_sq_r + r1_sq_i;
            r3_data <= n3_data;
        end
    end

    always_comb begin
        case (r1_op)
            OP_MUL: begin
                n2_x_r = 65'(r1_p_rr) - 65'(r1_p_ii);
                n2_x_i = 65'(r1_p_ri) + 65'(r1_p_ir);
            end
            OP_DIV: begin
                // A * conj(B)
                n2_x_r = 65'(r1_p_rr) + 65'(r1_p_ii);
                n2_x_i = 65'(r1_p_ir) - 65'(r1_p_ri);
            end
            default: begin
                n2_x_r = 65'(r1_s_r);
                n2_x_i = 65'(r1_s_i);
            end
        endcase
    end

    always_comb begin
        n3_data.op    = r2_op;
        n3_data.neg_r = r2_x_r[64];
        n3_data.neg_i = r2_x_i[64];
        n3_data.mag_r = r2_x_r[64] ? MAG_W'(-r2_x_r) : MAG_W'(r2_x_r);
        n3_data.mag_i = r2_x_i[64] ? MAG_W'(-r2_x_i) : MAG_W'(r2_x_i);
        n3_data.den   = r2_den;
        n3_data.dz    = (r2_op == OP_DIV) && (r2_den == '0);
    end

endmodule

// File: rtl/cau_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_lane
// Pipelined restoring divider: one quotient bit per stage, rounded at the end.
// ----------------------------------------------------------------------------
module cau_div_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cau_pkg::MAG_W-1:0]   i_num,
    input  logic [cau_pkg::DEN_W-1:0]   i_den,
    output logic                        o_big,
    output logic [cau_pkg::QUO_W-1:0]   o_quo
);
    import cau_pkg::*;

    logic [DEN_W-1:0] r_p   [DIV_STAGES];
    logic [QBITS-1:0] r_l   [DIV_STAGES];
    logic [QUO_W-1:0] r_q   [DIV_STAGES];
    logic [DEN_W-1:0] r_d   [DIV_STAGES];
    logic             r_big [DIV_STAGES];
    logic [DEN_W-1:0] n_p   [DIV_STAGES];
    logic [QBITS-1:0] n_l   [DIV_STAGES];
    logic [QUO_W-1:0] n_q   [DIV_STAGES];
    logic [DIV_W-1:0] scaled;

    assign scaled = {i_num, FRAC_BITS'(0)};
    assign o_big  = r_big[DIV_STAGES-1];
    assign o_quo  = r_q[DIV_STAGES-1];

    always_comb begin
        logic [DEN_W:0] v_sh;
        logic           v_ge;
        n_p[0] = DEN_W'(scaled[DIV_W-1:QBITS]);
        n_l[0] = scaled[QBITS-1:0];
        n_q[0] = '0;
        for (int k = 1; k <= QBITS; k++) begin
            v_sh   = {r_p[k-1], r_l[k-1][QBITS-1]};
            v_ge   = v_sh >= {1'b0, r_d[k-1]};
            n_p[k] = v_ge ? DEN_W'(v_sh - {1'b0, r_d[k-1]}) : v_sh[DEN_W-1:0];
            n_l[k] = r_l[k-1] << 1;
            n_q[k] = {r_q[k-1][QUO_W-2:0], v_ge};
        end
        // round half away from zero: 2*rem >= den
        v_ge = {r_p[DIV_STAGES-2], 1'b0} >= {1'b0, r_d[DIV_STAGES-2]};
        n_p[DIV_STAGES-1] = r_p[DIV_STAGES-2];
        n_l[DIV_STAGES-1] = r_l[DIV_STAGES-2];
        n_q[DIV_STAGES-1] = r_q[DIV_STAGES-2] + QUO_W'(v_ge);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient at or above 2^QBITS saturates whatever the sign
            r_big[0] <= DEN_W'(scaled[DIV_W-1:QBITS]) >= i_den;
            r_d[0]   <= i_den;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_p[k] <= n_p[k];
                r_l[k] <= n_l[k];
                r_q[k] <= n_q[k];
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_big[k] <= r_big[k-1];
                r_d[k]   <= r_d[k-1];
            end
        end
    end

endmodule

// File: rtl/cau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// Divider section: two quotient lanes sharing one stall and one valid track.
// ----------------------------------------------------------------------------
module cau_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  cau_pkg::t_prep              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output cau_pkg::t_prep              o_data,
    output logic                        o_big_r,
    output logic [cau_pkg::QUO_W-1:0]   o_quo_r,
    output logic                        o_big_i,
    output logic [cau_pkg::QUO_W-1:0]   o_quo_i
);
    import cau_pkg::*;

    logic  r_v    [DIV_STAGES];
    t_prep r_side [DIV_STAGES];
    logic  en;

    assign en      = !r_v[DIV_STAGES-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_data  = r_side[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= i_data;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    cau_div_lane u_lane_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_data.mag_r),
        .i_den (i_data.den),
        .o_big (o_big_r),
        .o_quo (o_quo_r)
    );

    cau_div_lane u_lane_i (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_data.mag_i),
        .i_den (i_data.den),
        .o_big (o_big_i),
        .o_quo (o_quo_i)
    );

endmodule

// File: rtl/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Result select, product rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  cau_pkg::t_prep              i_data,
    input  logic                        i_big_r,
    input  logic [cau_pkg::QUO_W-1:0]   i_quo_r,
    input  logic                        i_big_i,
    input  logic [cau_pkg::QUO_W-1:0]   i_quo_i,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_res_real,
    output logic signed [31:0]          o_res_imag,
    output logic                        o_overflow,
    output logic                        o_div_by_zero
);
    import cau_pkg::*;

    logic        r_v, en;
    logic [32:0] lane_r, lane_i;
    logic [31:0] r_res_r, r_res_i;
    logic        r_ovf, r_dz;

    // returns {saturated, value}
    function automatic logic [32:0] sat_lane(input logic [1:0] op, input logic neg,
                                             input logic [MAG_W-1:0] mag,
                                             input logic big,
                                             input logic [QUO_W-1:0] quo);
        logic [MAG_W:0] v;
        logic           force_sat;
        logic           sat;
        case (op)
            OP_MUL: begin
                v         = (MAG_W+1)'((mag + RND_HALF) >> FRAC_BITS);
                force_sat = 1'b0;
            end
            OP_DIV: begin
                v         = (MAG_W+1)'(quo);
                force_sat = big;
            end
            default: begin
                v         = (MAG_W+1)'(mag);
                force_sat = 1'b0;
            end
        endcase
        sat = force_sat || (!neg && v > (MAG_W+1)'(32'h7FFF_FFFF))
                        || (neg && v > (MAG_W+1)'(32'h8000_0000));
        if (sat) begin
            return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, neg ? 32'(-v[31:0]) : v[31:0]};
    endfunction

    assign lane_r = sat_lane(i_data.op, i_data.neg_r, i_data.mag_r, i_big_r, i_quo_r);
    assign lane_i = sat_lane(i_data.op, i_data.neg_i, i_data.mag_i, i_big_i, i_quo_i);

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_res_real    = r_res_r;
    assign o_res_imag    = r_res_i;
    assign o_overflow    = r_ovf;
    assign o_div_by_zero = r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dz <= i_data.dz;
            if (i_data.dz) begin
                r_res_r <= '0;
                r_res_i <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_res_r <= lane_r[31:0];
                r_res_i <= lane_i[31:0];
                r_ovf   <= lane_r[32] || lane_i[32];
            end
        end
    end

endmodule

// File: rtl/complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// Add, subtract, multiply or divide of two Q16.16 complex numbers.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the output stalls, and returns one
// result per transaction, in order, through three stages of products and
// sign/magnitude setup, 35 divider stages (one quotient bit per stage plus
// setup and rounding) and one output register. The divider depth sets the
// latency for every operation. Products round to nearest, ties away from
// zero; quotients are exact and rounded once; out-of-range parts saturate and
// set o_overflow. A zero divisor gives zero parts and o_div_by_zero.
module complex_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic               o_overflow,
    output logic               o_div_by_zero
);
    import cau_pkg::*;

    logic             f_valid, f_ready, d_valid, d_ready;
    t_prep            f_data, d_data;
    logic             big_r, big_i;
    logic [QUO_W-1:0] quo_r, quo_i;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_data   (f_data)
    );

    cau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_data  (d_data),
        .o_big_r (big_r),
        .o_quo_r (quo_r),
        .o_big_i (big_i),
        .o_quo_i (quo_i)
    );

    cau_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (d_valid),
        .o_ready       (d_ready),
        .i_data        (d_data),
        .i_big_r       (big_r),
        .i_quo_r       (quo_r),
        .i_big_i       (big_i),
        .i_quo_i       (quo_i),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_res_real    (o_res_real),
        .o_res_imag    (o_res_imag),
        .o_overflow    (o_overflow),
        .o_div_by_zero (o_div_by_zero)
    );

endmodule

// File: rtl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_macros.svh"

module cau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_res_real,
    input logic signed [31:0] o_res_imag,
    input logic               o_overflow,
    input logic               o_div_by_zero
);

    logic res_zero;
    logic res_rail;

    assign res_zero = (o_res_real == 32'sd0) && (o_res_imag == 32'sd0) && !o_overflow;
    assign res_rail = (o_res_real == 32'h7FFF_FFFF) || (o_res_real == 32'h8000_0000)
                   || (o_res_imag == 32'h7FFF_FFFF) || (o_res_imag == 32'h8000_0000);

    // a result not taken stays offered
    `CAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")

    // an empty output stage means the whole pipe can advance
    `CAU_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready, "input stalled")

    `CAU_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_valid && o_div_by_zero, res_zero, "dz not cleared")

    // overflow only with at least one part at a rail
    `CAU_ASSERT_IMP(a_ovf_rail, i_clk, i_rst_n, o_valid && o_overflow, res_rail, "ovf off rail")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// File: sim/complex_arith_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_checker
// Watches both channels of the complex arithmetic unit, computes the exact
// expected result of every accepted operation and compares it in order.
// ----------------------------------------------------------------------------
module complex_arith_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_res_real,
    input  logic signed [31:0] i_res_imag,
    input  logic               i_overflow,
    input  logic               i_div_by_zero,
    output int                 o_errors,
    output int                 o_pending
);
    import cau_pkg::*;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        logic        dz;
    } t_cplx_res;

    t_cplx_res expected_q[$];

    // clamp a signed exact value to Q16.16 range
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // round-half-away-from-zero of num * 2^FRAC_BITS / den (den > 0)
    function automatic logic signed [127:0] div_rnd(input logic signed [127:0] num,
                                                    input logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num < 0 ? 128'(-num) : 128'(num);
        q = ((mag << (FRAC_BITS + 1)) + den) / (den << 1);
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [127:0] shr_rnd(input logic signed [127:0] v);
        logic [127:0] mag;
        mag = v < 0 ? 128'(-v) : 128'(v);
        mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic t_cplx_res complex_result(input logic [1:0] op,
                                                 input logic signed [31:0] ar,
                                                 input logic signed [31:0] ai,
                                                 input logic signed [31:0] br,
                                                 input logic signed [31:0] bi);
        t_cplx_res r;
        logic signed [127:0] xr, xi, ar_w, ai_w, br_w, bi_w;
        logic [127:0] den;
        logic ovf;
        ovf = 1'b0;
        r = '0;
        ar_w = ar; ai_w = ai; br_w = br; bi_w = bi;
        case (op)
            OP_ADD: begin xr = ar_w + br_w; xi = ai_w + bi_w; end
            OP_SUB: begin xr = ar_w - br_w; xi = ai_w - bi_w; end
            OP_MUL: begin
                xr = shr_rnd(ar_w * br_w - ai_w * bi_w);
                xi = shr_rnd(ar_w * bi_w + br_w * ai_w);
            end
            default: begin
                den = br_w * br_w + bi_w * bi_w;
                xr = 0; xi = 0;
                if (den != 0) begin
                    xr = div_rnd(ar_w * br_w + ai_w * bi_w, den);
                    xi = div_rnd(ai_w * br_w - ar_w * bi_w, den);
                end else begin
                    r.dz = 1'b1;
                end
            end
        endcase
        r.re = clamp32(xr, ovf);
        r.im = clamp32(xi, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_cplx_res got, exp_r;
        if (!i_rst_n) begin
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(complex_result(i_op, i_a_real, i_a_imag,
                                                    i_b_real, i_b_imag));
            if (i_out_valid && i_out_ready) begin
                got = '{i_res_real, i_res_imag, i_overflow, i_div_by_zero};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r) begin
                        $display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b",
                                 $time, exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz);
                        $display("%0t:          actual   re=%h im=%h ovf=%b dz=%b",
                                 $time, got.re, got.im, got.ovf, got.dz);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/complex_arith_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_tb
// Directed corner operands, then random operations with bursty idling on both
// channels; results are checked in order by the checker module.
// ----------------------------------------------------------------------------
module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam int N_RANDOM  = 430;
    localparam int LATENCY   = 39;
    localparam int MAX_CYCLE = 200000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] a_real, a_imag, b_real, b_imag;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] res_real, res_imag;
    logic               overflow, div_by_zero;
    int                 errors;
    int                 pending;
    int                 cycle = 0;
    bit                 quiet;

    complex_arith_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_op(op), .i_a_real(a_real), .i_a_imag(a_imag),
        .i_b_real(b_real), .i_b_imag(b_imag),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_res_real(res_real), .o_res_imag(res_imag),
        .o_overflow(overflow), .o_div_by_zero(div_by_zero)
    );

    complex_arith_unit_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_op(op), .i_a_real(a_real), .i_a_imag(a_imag),
        .i_b_real(b_real), .i_b_imag(b_imag),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_res_real(res_real), .i_res_imag(res_imag),
        .i_overflow(overflow), .i_div_by_zero(div_by_zero),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 11);
            end else begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            repeat (n) @(posedge clk);
        end
    end

    // random operand biased toward edge values
    function automatic logic [31:0] operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1023)) - 512) <<< 16;
            3: return 32'($signed($urandom_range(0, 255)) - 128);
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [1:0] o, input logic [31:0] ar, input logic [31:0] ai,
                        input logic [31:0] br, input logic [31:0] bi);
        in_valid <= 1'b1;
        op <= o; a_real <= ar; a_imag <= ai; b_real <= br; b_imag <= bi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    initial begin
        logic [31:0] corner[6];
        logic [31:0] b_r, b_i;
        int wait_cnt;
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000,
                   32'hFFFF_0000, 32'h0000_8000};
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ADD;
        a_real = '0; a_imag = '0; b_real = '0; b_imag = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: saturation each way, zero divisor, ties
        send(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
        send(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
        send(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001);
        send(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send(OP_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);
        send(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0000_0003, 32'h0000_0004);
        for (int k = 0; k < 12; k++)
            send(2'(k % 4), corner[k % 6], corner[(k + 1) % 6],
                 corner[(k + 2) % 6], corner[(k + 3) % 6]);

        // every result back before the random part
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 60)
                quiet = 1'b1;
            sender_gap();
            b_r = operand();
            b_i = operand();
            send(2'($urandom_range(0, 3)), operand(), operand(), b_r, b_i);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < 2 * LATENCY) begin
            @(posedge clk);
            wait_cnt++;
        end
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_lane.sv
rtl/cau_div.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
rtl/cau_checker.sv
sim/complex_arith_unit_checker.sv
sim/complex_arith_unit_tb.sv
